FILE: hw/rtl/chroma_bilinear_edge_clamped_fetch_macros.svh
// Assertion macros for the chroma bilinear fetch checker.
// Each macro expects clk and arst_n in scope where it is used.
`ifndef CHROMA_BILINEAR_EDGE_CLAMPED_FETCH_MACROS_SVH
`define CHROMA_BILINEAR_EDGE_CLAMPED_FETCH_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define CBF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Antecedent in a given cycle, consequent from the next cycle on.
`define CBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	`CBF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: hw/rtl/cbf_pkg.sv
// Shared types and constants of the chroma bilinear fetch block.
// No dependencies; every file but cbf_ram and the macro header imports this package.
package cbf_pkg;

	localparam int POS_W      = 10;
	localparam int SAMPLE_W   = 8;
	localparam int SIZE_REG_W = 9;
	localparam int FRAC_W     = 3;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 9;

	// Bilinear weights: (8-f) factors, products up to 64
	localparam int FRAC_ONE  = 8;
	localparam int WT_W      = 7;
	localparam int ROUND     = 32;
	localparam int SHIFT     = 6;

	localparam int TAP_W     = 2;
	localparam int NUM_TAPS  = 4;
	// Bit 0 of a tap selects column x+1, bit 1 selects row y+1
	localparam logic [TAP_W-1:0] TAP_FIRST = 2'd0;
	localparam logic [TAP_W-1:0] TAP_RIGHT = 2'd1;
	localparam logic [TAP_W-1:0] TAP_BELOW = 2'd2;
	localparam logic [TAP_W-1:0] TAP_LAST  = 2'd3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [CFG_ADDR_W-1:0] REG_FRAC_X  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FRAC_Y  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_WIDTH   = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT  = 2'd3;

	localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 9'd256;

	// Read issued to the sample store, tagged with its neighbour
	typedef struct packed {
		logic                 valid;
		logic [TAP_W-1:0]     tap;
	} cbf_rd_tag_t;

endpackage

FILE: hw/rtl/cbf_if.sv
// Valid/ready channel interfaces: request items, result items, register writes.
// Depends on cbf_pkg for field widths.
interface cbf_item_if import cbf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic                       plane;
	logic signed [POS_W-1:0]    pos_x;
	logic signed [POS_W-1:0]    pos_y;
	logic [SAMPLE_W-1:0]        sample_in;

	modport source (output valid, op, plane, pos_x, pos_y, sample_in, input ready);
	modport sink (input valid, op, plane, pos_x, pos_y, sample_in, output ready);
endinterface

interface cbf_result_if import cbf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [SAMPLE_W-1:0]        sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink (input valid, sample_out, output ready);
endinterface

interface cbf_cfg_if import cbf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CFG_ADDR_W-1:0]      addr;
	logic [CFG_DATA_W-1:0]      data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

FILE: hw/rtl/chroma_bilinear_edge_clamped_fetch.sv
// Chroma eighth-pel bilinear fetch with edge clamping. Holds the U and V planes
// of one reference picture in a single-port sample store of 2*2**YW*2**XW entries
// (height and width padded to powers of two). A write item is accepted and then
// written and gives no result; writes outside the picture are dropped. A read item
// is accepted and clamped, then makes one store read per neighbour through the
// single port, so the store port sets the rate. The last read waits while the
// previous result still sits in the output register. The store needs no clearing
// pass; reading a sample never written returns undefined data. Register writes are
// always accepted (cfg.ready is tied high) and must happen while the block is idle.
// Depends on cbf_pkg, cbf_if, cbf_ram, cbf_ctrl, cbf_mac.
module chroma_bilinear_edge_clamped_fetch import cbf_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int PIXEL_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	cbf_item_if.sink        item,
	cbf_result_if.source    result,
	cbf_cfg_if.sink         cfg
);

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = 1 + YW + XW;
	localparam int DEPTH = 2 ** AW;

	logic [FRAC_W-1:0]      frac_x_q, frac_y_q;
	logic [SIZE_REG_W-1:0]  width_q, height_q;

	logic                   ram_we;
	logic [AW-1:0]          ram_addr;
	logic [PIXEL_BITS-1:0]  ram_wdata, ram_rdata;
	cbf_rd_tag_t            rd_tag;
	logic                   out_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_x_q <= '0;
			frac_y_q <= '0;
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_FRAC_X: frac_x_q <= cfg.data[FRAC_W-1:0];
				REG_FRAC_Y: frac_y_q <= cfg.data[FRAC_W-1:0];
				REG_WIDTH:  width_q  <= cfg.data[SIZE_REG_W-1:0];
				REG_HEIGHT: height_q <= cfg.data[SIZE_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign out_free = !result.valid || result.ready;

	cbf_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.pic_width  (width_q),
		.pic_height (height_q),
		.out_free   (out_free),
		.ram_we     (ram_we),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata),
		.rd_tag     (rd_tag)
	);

	cbf_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	cbf_mac #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.frac_x  (frac_x_q),
		.frac_y  (frac_y_q),
		.rd_tag  (rd_tag),
		.rd_data (ram_rdata),
		.result  (result)
	);

endmodule

FILE: hw/rtl/cbf_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module cbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: hw/rtl/cbf_ctrl.sv
// Request sequencer: clamps coordinates, writes samples, issues four neighbour reads.
// Depends on cbf_pkg and cbf_if.
module cbf_ctrl import cbf_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int PIXEL_BITS = 8,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT),
	localparam int AW = 1 + YW + XW
) (
	input  logic                    clk,
	input  logic                    arst_n,
	cbf_item_if.sink                item,
	input  logic [SIZE_REG_W-1:0]   pic_width,
	input  logic [SIZE_REG_W-1:0]   pic_height,
	input  logic                    out_free,
	output logic                    ram_we,
	output logic [AW-1:0]           ram_addr,
	output logic [PIXEL_BITS-1:0]   ram_wdata,
	output cbf_rd_tag_t             rd_tag
);

	localparam int XS  = $clog2(MAX_WIDTH + 1);
	localparam int YS  = $clog2(MAX_HEIGHT + 1);
	localparam int M1  = (XS > YS) ? XS : YS;
	localparam int M2  = (SIZE_REG_W > POS_W) ? SIZE_REG_W : POS_W;
	localparam int CW  = ((M1 > M2) ? M1 : M2) + 2;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WRITE = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;

	function automatic logic signed [CW-1:0] eff_size(
		input logic [SIZE_REG_W-1:0] v,
		input logic signed [CW-1:0]  maxv
	);
		logic signed [CW-1:0] ve;
		ve = $signed(CW'(v));
		if (v == '0) begin
			return $signed(CW'(1));
		end
		if (ve > maxv) begin
			return maxv;
		end
		return ve;
	endfunction

	function automatic logic signed [CW-1:0] clamp_pos(
		input logic signed [CW-1:0] p,
		input logic signed [CW-1:0] size
	);
		if (p < $signed(CW'(0))) begin
			return '0;
		end
		if (p >= size) begin
			return size - $signed(CW'(1));
		end
		return p;
	endfunction

	logic [1:0]             state_q;
	logic [TAP_W-1:0]       tap_q;
	logic                   plane_q;
	logic                   wr_ok_q;
	logic [XW-1:0]          x0_q, x1_q;
	logic [YW-1:0]          y0_q, y1_q;
	logic [PIXEL_BITS-1:0]  sample_q;

	logic signed [CW-1:0]   w_eff, h_eff, px, py, px1, py1;
	logic signed [CW-1:0]   cx0, cx1, cy0, cy1;
	logic                   wr_ok;
	logic                   accept;
	logic                   issue;
	logic [XW-1:0]          x_sel;
	logic [YW-1:0]          y_sel;

	always_comb begin
		w_eff = eff_size(pic_width, $signed(CW'(MAX_WIDTH)));
		h_eff = eff_size(pic_height, $signed(CW'(MAX_HEIGHT)));
		px    = CW'(item.pos_x);
		py    = CW'(item.pos_y);
		px1   = px + $signed(CW'(1));
		py1   = py + $signed(CW'(1));
		cx0   = clamp_pos(px, w_eff);
		cx1   = clamp_pos(px1, w_eff);
		cy0   = clamp_pos(py, h_eff);
		cy1   = clamp_pos(py1, h_eff);
		wr_ok = (px >= $signed(CW'(0))) && (py >= $signed(CW'(0)))
			&& (px < w_eff) && (py < h_eff);
	end

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;

	// Hold the diagonal read until the output register is free for its result
	assign issue = (state_q == ST_READ) && ((tap_q != TAP_LAST) || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= TAP_FIRST;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					tap_q <= TAP_FIRST;
					if (accept) begin
						state_q <= (item.op == OP_READ) ? ST_READ : ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					if (issue) begin
						tap_q <= tap_q + TAP_W'(1);
						if (tap_q == TAP_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			plane_q  <= item.plane;
			wr_ok_q  <= wr_ok;
			x0_q     <= cx0[XW-1:0];
			x1_q     <= cx1[XW-1:0];
			y0_q     <= cy0[YW-1:0];
			y1_q     <= cy1[YW-1:0];
			sample_q <= PIXEL_BITS'(item.sample_in);
		end
	end

	// Writes use tap zero, so the address is the unclamped in-range position
	assign x_sel     = tap_q[0] ? x1_q : x0_q;
	assign y_sel     = tap_q[1] ? y1_q : y0_q;
	assign ram_addr  = {plane_q, y_sel, x_sel};
	assign ram_we    = (state_q == ST_WRITE) && wr_ok_q;
	assign ram_wdata = sample_q;

	assign rd_tag.valid = issue;
	assign rd_tag.tap   = tap_q;

endmodule

FILE: hw/rtl/cbf_mac.sv
// Weighted accumulation of the four neighbours, rounding and result register.
// Depends on cbf_pkg and cbf_if.
module cbf_mac import cbf_pkg::*; #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [FRAC_W-1:0]       frac_x,
	input  logic [FRAC_W-1:0]       frac_y,
	input  cbf_rd_tag_t             rd_tag,
	input  logic [PIXEL_BITS-1:0]   rd_data,
	cbf_result_if.source            result
);

	localparam int ACC_W = PIXEL_BITS + SHIFT;

	cbf_rd_tag_t           tag_s1;
	logic [WT_W-1:0]       wt_q [NUM_TAPS];
	logic [ACC_W-1:0]      acc_q;
	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   out_data_q;

	logic [FRAC_W:0]       ix, iy;
	logic [ACC_W-1:0]      prod, sum, rounded;

	assign ix = (FRAC_W+1)'(FRAC_ONE) - {1'b0, frac_x};
	assign iy = (FRAC_W+1)'(FRAC_ONE) - {1'b0, frac_y};

	// Weights follow the registers; they are stable long before a read lands
	always_ff @(posedge clk) begin
		wt_q[TAP_FIRST] <= WT_W'(ix) * WT_W'(iy);
		wt_q[TAP_RIGHT] <= WT_W'(frac_x) * WT_W'(iy);
		wt_q[TAP_BELOW] <= WT_W'(ix) * WT_W'(frac_y);
		wt_q[TAP_LAST]  <= WT_W'(frac_x) * WT_W'(frac_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= rd_tag;
		end
	end

	always_comb begin
		prod    = ACC_W'(wt_q[tag_s1.tap]) * ACC_W'(rd_data);
		sum     = ((tag_s1.tap == TAP_FIRST) ? '0 : acc_q) + prod;
		rounded = sum + ACC_W'(ROUND);
	end

	always_ff @(posedge clk) begin
		if (tag_s1.valid) begin
			acc_q <= sum;
		end
		if (tag_s1.valid && (tag_s1.tap == TAP_LAST)) begin
			out_data_q <= rounded[SHIFT +: SAMPLE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tag_s1.valid && (tag_s1.tap == TAP_LAST)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = out_data_q;

endmodule

FILE: hw/rtl/cbf_checker.sv
// Port-level checker for the chroma bilinear fetch, bound to the top level.
// Depends on cbf_pkg and the assertion macro header.
`include "chroma_bilinear_edge_clamped_fetch_macros.svh"

module cbf_checker import cbf_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_ready,
	input logic                 item_op,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [SAMPLE_W-1:0]  res_data
);

	logic item_xfer;

	assign item_xfer = item_valid && item_ready;

	// A stalled result keeps its value
	`CBF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result changed while stalled")

	// One item at a time: no transfer right after a transfer
	`CBF_ASSERT_NEXT(a_one_item, item_xfer, !item_ready, "request taken back to back")

	// A read walks four neighbours through the store port before the next request
	`CBF_ASSERT_NEXT(a_read_busy, item_xfer && (item_op == OP_READ), !item_ready ##1 !item_ready ##1 !item_ready ##1 !item_ready, "read finished too early")

	// A write frees the request side right after its write state
	`CBF_ASSERT_NEXT(a_write_done, item_xfer && (item_op == OP_WRITE), ##1 item_ready, "write did not finish")

endmodule

bind chroma_bilinear_edge_clamped_fetch cbf_checker u_cbf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.item_op    (item.op),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_data   (result.sample_out)
);

FILE: tb/sv/chroma_bilinear_edge_clamped_fetch_tb.sv
`timescale 1ns / 100ps
// Testbench for the chroma bilinear fetch: drives write and read requests, predicts
// every interpolated sample and checks the result channel in order.
// Depends on cbf_pkg, the cbf_if interfaces and chroma_bilinear_edge_clamped_fetch.
module chroma_bilinear_edge_clamped_fetch_tb;
	import cbf_pkg::*;

	localparam int MAX_W         = 256;
	localparam int MAX_H         = 256;
	localparam int PAD           = 32;
	localparam int PLANE_WORDS   = MAX_W * MAX_H;
	localparam int STORE_DEPTH   = 2 * PLANE_WORDS;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 500;
	localparam int STALL_LIMIT   = 4000;
	localparam int SHOW_ERRORS   = 10;

	typedef struct {
		logic                    op;
		logic                    plane;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [SAMPLE_W-1:0]     sample_in;
	} fetch_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cbf_item_if   item_ch ();
	cbf_result_if result_ch ();
	cbf_cfg_if    cfg_ch ();

	chroma_bilinear_edge_clamped_fetch uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Register copies, sample store copy and the generator's record of written entries
	logic [FRAC_W-1:0]     fx_reg;
	logic [FRAC_W-1:0]     fy_reg;
	logic [SIZE_REG_W-1:0] width_reg;
	logic [SIZE_REG_W-1:0] height_reg;
	logic [SAMPLE_W-1:0]   plane_mem [0:STORE_DEPTH-1];
	bit                    gen_filled [0:STORE_DEPTH-1];

	fetch_req_t          req_backlog[$];
	logic [SAMPLE_W-1:0] interp_expected[$];
	int                  items_planned = 0;
	int                  error_count = 0;
	int                  src_idle_pct = 0;
	int                  snk_stall_pct = 0;
	int                  hold_requests = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int eff_dim(logic [SIZE_REG_W-1:0] r, int maxv);
		if (r == 0)
			return 1;
		if (r > maxv)
			return maxv;
		return r;
	endfunction

	function automatic int clamp_dim(int p, int size);
		if (p < 0)
			return 0;
		if (p >= size)
			return size - 1;
		return p;
	endfunction

	function automatic int store_addr(logic pl, int x, int y);
		return (pl ? PLANE_WORDS : 0) + y * MAX_W + x;
	endfunction

	function automatic int pick_coord(int size);
		case ($urandom_range(0, 15))
			0: return int'($urandom_range(0, 1023)) - 512;
			1: return -PAD;
			2: return size - 1 + PAD;
			3: return -PAD - 1;
			default: begin
				if (size <= 40)
					return int'($urandom_range(0, size + 2 * PAD - 1)) - PAD;
				else if ($urandom_range(0, 1))
					return int'($urandom_range(0, 47)) - PAD;
				else
					return size - 16 + int'($urandom_range(0, 47));
			end
		endcase
	endfunction

	function automatic int pick_outside(int size);
		if ($urandom_range(0, 1))
			return -1 - int'($urandom_range(0, 511));
		return size + int'($urandom_range(0, 511 - size));
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		return SAMPLE_W'($urandom_range(0, 255));
	endfunction

	task automatic report(string what, logic [SAMPLE_W-1:0] exp_v,
			logic [SAMPLE_W-1:0] act_v);
		error_count++;
		if (error_count <= SHOW_ERRORS)
			$display("%s: expected %0d got %0d at %0t", what, exp_v, act_v, $realtime);
	endtask

	task automatic queue_write(logic pl, int x, int y, logic [SAMPLE_W-1:0] v);
		fetch_req_t r;
		int w;
		int h;
		w = eff_dim(width_reg, MAX_W);
		h = eff_dim(height_reg, MAX_H);
		r.op = OP_WRITE;
		r.plane = pl;
		r.pos_x = x[POS_W-1:0];
		r.pos_y = y[POS_W-1:0];
		r.sample_in = v;
		req_backlog.push_back(r);
		items_planned++;
		if (x >= 0 && y >= 0 && x < w && y < h)
			gen_filled[store_addr(pl, x, y)] = 1'b1;
	endtask

	// Fill any unwritten neighbour first so the read never touches undefined data
	task automatic queue_read(logic pl, int x, int y);
		fetch_req_t r;
		int w;
		int h;
		int xs[2];
		int ys[2];
		w = eff_dim(width_reg, MAX_W);
		h = eff_dim(height_reg, MAX_H);
		xs[0] = clamp_dim(x, w);
		xs[1] = clamp_dim(x + 1, w);
		ys[0] = clamp_dim(y, h);
		ys[1] = clamp_dim(y + 1, h);
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++)
				if (!gen_filled[store_addr(pl, xs[i], ys[j])])
					queue_write(pl, xs[i], ys[j], rand_sample());
		r.op = OP_READ;
		r.plane = pl;
		r.pos_x = x[POS_W-1:0];
		r.pos_y = y[POS_W-1:0];
		r.sample_in = rand_sample();
		req_backlog.push_back(r);
		items_planned++;
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= a;
		cfg_ch.data <= d;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (a)
			REG_FRAC_X: fx_reg = d[FRAC_W-1:0];
			REG_FRAC_Y: fy_reg = d[FRAC_W-1:0];
			REG_WIDTH:  width_reg = d[SIZE_REG_W-1:0];
			REG_HEIGHT: height_reg = d[SIZE_REG_W-1:0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
	endtask

	// Wait out every queued request and result, then the tail of a last write
	task automatic settle();
		while (req_backlog.size() != 0 || item_ch.valid || interp_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int n);
		int stop;
		int w;
		int h;
		int roll;
		logic pl;
		stop = items_planned + n;
		w = eff_dim(width_reg, MAX_W);
		h = eff_dim(height_reg, MAX_H);
		while (items_planned < stop) begin
			roll = $urandom_range(0, 99);
			pl = 1'($urandom_range(0, 1));
			if (roll < 60)
				queue_read(pl, pick_coord(w), pick_coord(h));
			else if (roll < 85)
				queue_write(pl, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
					rand_sample());
			else if ($urandom_range(0, 1))
				queue_write(pl, pick_outside(w), $urandom_range(0, h - 1),
					rand_sample());
			else
				queue_write(pl, $urandom_range(0, w - 1), pick_outside(h),
					rand_sample());
		end
	endtask

	task automatic run_phase(logic [CFG_DATA_W-1:0] fx, logic [CFG_DATA_W-1:0] fy,
			logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h, int src_pct, int snk_pct,
			int n, bit pressure);
		write_reg(REG_FRAC_X, fx);
		write_reg(REG_FRAC_Y, fy);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		run_random(n);
		if (pressure) begin
			@(posedge clk);
			hold_requests <= hold_requests + 1;
		end
		settle();
	endtask

	// Request driver: predict on each transfer, then offer the next pending request
	always @(posedge clk or negedge arst_n) begin : drive_requests
		fetch_req_t offer;
		int w;
		int h;
		int px;
		int py;
		int x0;
		int x1;
		int y0;
		int y1;
		int fx;
		int fy;
		int acc;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.op <= OP_WRITE;
			item_ch.plane <= 1'b0;
			item_ch.pos_x <= '0;
			item_ch.pos_y <= '0;
			item_ch.sample_in <= '0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				w = eff_dim(width_reg, MAX_W);
				h = eff_dim(height_reg, MAX_H);
				px = offer.pos_x;
				py = offer.pos_y;
				if (offer.op == OP_WRITE) begin
					if (px >= 0 && py >= 0 && px < w && py < h)
						plane_mem[store_addr(offer.plane, px, py)] = offer.sample_in;
				end else begin
					x0 = clamp_dim(px, w);
					x1 = clamp_dim(px + 1, w);
					y0 = clamp_dim(py, h);
					y1 = clamp_dim(py + 1, h);
					fx = fx_reg;
					fy = fy_reg;
					acc = (FRAC_ONE - fx) * (FRAC_ONE - fy)
							* plane_mem[store_addr(offer.plane, x0, y0)]
						+ fx * (FRAC_ONE - fy) * plane_mem[store_addr(offer.plane, x1, y0)]
						+ (FRAC_ONE - fx) * fy * plane_mem[store_addr(offer.plane, x0, y1)]
						+ fx * fy * plane_mem[store_addr(offer.plane, x1, y1)];
					acc = (acc + ROUND) >> SHIFT;
					interp_expected.push_back(acc[SAMPLE_W-1:0]);
				end
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (req_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					offer = req_backlog.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.op <= offer.op;
					item_ch.plane <= offer.plane;
					item_ch.pos_x <= offer.pos_x;
					item_ch.pos_y <= offer.pos_y;
					item_ch.sample_in <= offer.sample_in;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each transfer with the oldest expected sample
	always @(posedge clk or negedge arst_n) begin : watch_results
		int hold_left;
		int hold_served;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left = 0;
			hold_served = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (interp_expected.size() == 0)
					report("unexpected sample", 'x, result_ch.sample_out);
				else if (result_ch.sample_out !== interp_expected[0])
					report("sample mismatch", interp_expected.pop_front(), result_ch.sample_out);
				else
					void'(interp_expected.pop_front());
			end
			// Hold off for a long stretch so the block backs up into its input
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("chroma_bilinear_edge_clamped_fetch_tb: errors");
		$finish;
	end

	initial begin : stimulus
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = REG_FRAC_X;
		cfg_ch.data = '0;
		fx_reg = '0;
		fy_reg = '0;
		width_reg = SIZE_RESET;
		height_reg = SIZE_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corners, edge replication, saturation, writes that miss the picture
		queue_write(1'b0, 0, 0, 8'd0);
		queue_write(1'b0, 255, 255, 8'd255);
		queue_write(1'b1, 0, 0, 8'd255);
		queue_write(1'b1, 255, 0, 8'h5A);
		queue_write(1'b0, -1, 0, 8'd255);
		queue_write(1'b0, 256, 3, 8'd255);
		queue_write(1'b1, 3, 256, 8'd255);
		queue_write(1'b0, -512, 511, 8'd255);
		queue_read(1'b0, 0, 0);
		queue_read(1'b0, -PAD, -PAD);
		queue_read(1'b0, MAX_W - 1 + PAD, MAX_H - 1 + PAD);
		queue_read(1'b1, -512, -512);
		queue_read(1'b1, 511, 511);
		queue_read(1'b1, 255, -1);
		settle();
		write_reg(REG_FRAC_X, 9'd7);
		write_reg(REG_FRAC_Y, 9'd7);
		queue_read(1'b0, 254, 254);
		queue_read(1'b0, 255, 255);
		queue_read(1'b1, 0, 0);
		queue_read(1'b1, -33, 100);
		queue_write(1'b1, 1, 1, 8'd0);
		queue_read(1'b1, 0, 0);
		settle();

		run_phase(9'd3, 9'd5, 9'd1, 9'd1, 0, 0, 50, 1'b0);
		// Fraction writes with high data bits, a zero width
		run_phase(9'h1FC, 9'h0F9, 9'd0, 9'd7, 80, 0, 60, 1'b0);
		run_phase(9'd1, 9'd6, 9'd5, 9'd3, 0, 80, 70, 1'b0);
		run_phase(9'd2, 9'd2, 9'd300, 9'd2, 6, 6, 70, 1'b1);
		run_phase(9'd5, 9'd0, 9'd17, 9'd511, 0, 0, 70, 1'b0);
		run_phase(9'd7, 9'd7, 9'd256, 9'd256, 80, 0, 70, 1'b0);
		run_phase(9'd0, 9'd0, 9'd2, 9'd2, 0, 80, 60, 1'b0);
		for (int k = 0; k < 3; k++)
			run_phase(CFG_DATA_W'($urandom_range(0, 7)), CFG_DATA_W'($urandom_range(0, 7)),
				CFG_DATA_W'($urandom_range(1, 40)), CFG_DATA_W'($urandom_range(1, 40)),
				(k == 1) ? 80 : 6, (k == 2) ? 80 : 6, 60, 1'b0);

		settle();
		if (error_count == 0 && interp_expected.size() == 0)
			$display("chroma_bilinear_edge_clamped_fetch_tb: clean");
		else
			$display("chroma_bilinear_edge_clamped_fetch_tb: errors");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/cbf_pkg.sv
hw/rtl/cbf_if.sv
hw/rtl/cbf_ram.sv
hw/rtl/cbf_ctrl.sv
hw/rtl/cbf_mac.sv
hw/rtl/chroma_bilinear_edge_clamped_fetch.sv
hw/rtl/cbf_checker.sv
tb/sv/chroma_bilinear_edge_clamped_fetch_tb.sv
